/* rtl/bctd_pkg.sv */
package bctd_pkg;

	// Directory geometry
	localparam int LINES        = 8;
	localparam int LINE_BITS    = (LINES > 1) ? $clog2(LINES) : 1;
	localparam int ADDRESS_BITS = 32;

	// Fixed field widths of the access and result items
	localparam int BLOCK_ADDR_W = 32;
	localparam int LINE_IDX_W   = 3;

	typedef logic [ADDRESS_BITS-1:0] tag_t;
	typedef logic [LINE_BITS-1:0]    line_t;

	typedef enum logic [1:0] {
		MODE_READ  = 2'd0,
		MODE_WRITE = 2'd1,
		MODE_INVAL = 2'd2,
		MODE_RSVD  = 2'd3
	} mode_t;

	// Compare only the low ADDRESS_BITS bits of the block address
	function automatic tag_t tag_of(input logic [BLOCK_ADDR_W-1:0] addr);
		logic [127:0] wide;
		wide = 128'(addr);
		return wide[ADDRESS_BITS-1:0];
	endfunction

	// Report a line number in the fixed-width result field
	function automatic logic [LINE_IDX_W-1:0] line_field(input line_t idx);
		logic [127:0] wide;
		wide = 128'(idx);
		return wide[LINE_IDX_W-1:0];
	endfunction

	// Round-robin step
	function automatic line_t next_line(input line_t idx);
		line_t nxt;
		if (idx == line_t'(LINES - 1)) begin
			nxt = '0;
		end else begin
			nxt = idx + line_t'(1);
		end
		return nxt;
	endfunction

endpackage

/* rtl/block_cache_tag_directory.sv */
// Channel  | valid      | stall      | payload
// ---------+------------+------------+------------------------------------------------
// access   | in_valid   | in_stall   | mode, block_address, device_ok
// result   | out_valid  | out_stall  | status, hit, line_index, fill_line, store_line,
//          |            |            | pass_through
// config   | cfg_we     | (none)     | cfg_wdata -> cache_enable
//
// An item is registered on acceptance and then looked up against all lines in
// parallel; the directory update and the result register load when that stage advances.
// One item per cycle is sustained while the result channel does not stall.
// Reset clears all valid bits, the replacement pointer and both stage valids, and
// sets cache_enable to 1; tags are not cleared since invalid lines never match.
// A stalled result holds the lookup stage, which then stalls the access channel.
module block_cache_tag_directory (
	input  logic                             clk,
	input  logic                             arst_n,

	input  logic                             cfg_we,
	input  logic                             cfg_wdata,

	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [1:0]                       mode,
	input  logic [bctd_pkg::BLOCK_ADDR_W-1:0] block_address,
	input  logic                             device_ok,

	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             status,
	output logic                             hit,
	output logic [bctd_pkg::LINE_IDX_W-1:0]  line_index,
	output logic                             fill_line,
	output logic                             store_line,
	output logic                             pass_through
);
	import bctd_pkg::*;

	// Directory state
	tag_t  line_tag_q [LINES];
	logic  [LINES-1:0] line_valid_q;
	line_t replace_ptr_q;
	logic  cache_enable_q;

	// Input register stage
	logic  valid_s1;
	mode_t mode_s1;
	tag_t  tag_s1;
	logic  ok_s1;

	// Result register stage
	logic                  valid_s2;
	logic                  status_s2;
	logic                  hit_s2;
	logic [LINE_IDX_W-1:0] line_s2;
	logic                  fill_s2;
	logic                  store_s2;
	logic                  pass_s2;

	// Lookup-stage decisions
	logic                  advance;
	logic                  take_in;
	logic                  match;
	line_t                 match_idx;
	logic                  r_status, r_hit, r_fill, r_store, r_pass;
	logic [LINE_IDX_W-1:0] r_line;
	logic                  do_inval;
	logic                  do_alloc;
	logic                  do_ptr_step;
	logic                  do_write_tag;
	line_t                 wr_idx;

	// The lookup stage moves on when the result register is free or drains this cycle
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign take_in  = in_valid && !in_stall;

	// Lowest valid matching line wins: scan from the top so lower lines overwrite
	always_comb begin
		match     = 1'b0;
		match_idx = '0;
		for (int i = LINES - 1; i >= 0; i--) begin
			if (line_valid_q[i] && (line_tag_q[i] == tag_s1)) begin
				match     = 1'b1;
				match_idx = line_t'(i);
			end
		end
	end

	// Decode the access against the directory
	always_comb begin
		r_status     = 1'b0;
		r_hit        = 1'b0;
		r_line       = '0;
		r_fill       = 1'b0;
		r_store      = 1'b0;
		r_pass       = 1'b0;
		do_inval     = 1'b0;
		do_alloc     = 1'b0;
		do_ptr_step  = 1'b0;
		do_write_tag = 1'b0;
		wr_idx       = replace_ptr_q;
		case (mode_s1)
			MODE_INVAL: begin
				do_inval = 1'b1;
			end
			MODE_READ, MODE_WRITE: begin
				if (!cache_enable_q) begin
					// Cache off: hand the item straight to the device
					r_status = !ok_s1;
					r_pass   = 1'b1;
				end else if (mode_s1 == MODE_READ) begin
					if (match) begin
						r_hit  = 1'b1;
						r_line = line_field(match_idx);
					end else begin
						// Miss: claim the pointed line whether or not the fill works
						do_ptr_step = 1'b1;
						r_line      = line_field(replace_ptr_q);
						if (ok_s1) begin
							do_write_tag = 1'b1;
							r_fill       = 1'b1;
						end else begin
							r_status = 1'b1;
						end
					end
				end else begin
					// Write-through: touch the directory only after the device accepts
					if (!ok_s1) begin
						r_status = 1'b1;
					end else if (match) begin
						r_hit   = 1'b1;
						r_line  = line_field(match_idx);
						r_store = 1'b1;
					end else begin
						do_ptr_step  = 1'b1;
						do_write_tag = 1'b1;
						r_line       = line_field(replace_ptr_q);
						r_store      = 1'b1;
					end
				end
			end
			default: begin
				// Reserved mode: drop with an all-zero result
			end
		endcase
		do_alloc = do_write_tag;
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cache_enable_q <= 1'b1;
		end else if (cfg_we) begin
			cache_enable_q <= cfg_wdata;
		end
	end

	// Input register: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register: payload
	always_ff @(posedge clk) begin
		if (take_in) begin
			mode_s1 <= mode_t'(mode);
			tag_s1  <= tag_of(block_address);
			ok_s1   <= device_ok;
		end
	end

	// Directory control state: valid bits and replacement pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_valid_q  <= '0;
			replace_ptr_q <= '0;
		end else if (advance) begin
			if (do_inval) begin
				line_valid_q  <= '0;
				replace_ptr_q <= '0;
			end else begin
				if (do_alloc) begin
					line_valid_q[wr_idx] <= 1'b1;
				end
				if (do_ptr_step) begin
					replace_ptr_q <= next_line(replace_ptr_q);
				end
			end
		end
	end

	// Tag storage; invalid lines are masked by their valid bit
	always_ff @(posedge clk) begin
		if (advance && do_write_tag) begin
			line_tag_q[wr_idx] <= tag_s1;
		end
	end

	// Result register: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	// Result register: payload, held while stalled
	always_ff @(posedge clk) begin
		if (advance) begin
			status_s2 <= r_status;
			hit_s2    <= r_hit;
			line_s2   <= r_line;
			fill_s2   <= r_fill;
			store_s2  <= r_store;
			pass_s2   <= r_pass;
		end
	end

	assign out_valid    = valid_s2;
	assign status       = status_s2;
	assign hit          = hit_s2;
	assign line_index   = line_s2;
	assign fill_line    = fill_s2;
	assign store_line   = store_s2;
	assign pass_through = pass_s2;

endmodule

/* tb/block_cache_tag_directory_test.sv */
module block_cache_tag_directory_test;
	import bctd_pkg::*;

	// Stop the run after this many cycles in a row with no item moving on either channel
	localparam int IDLE_LIMIT = 5000;
	localparam int MAX_REPORTS = 10;

	// One result item, in the order of the result ports
	typedef struct packed {
		logic                  status;
		logic                  hit;
		logic [LINE_IDX_W-1:0] line_index;
		logic                  fill_line;
		logic                  store_line;
		logic                  pass_through;
	} outcome_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_we = 1'b0;
	logic                    cfg_wdata = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic [1:0]              mode = MODE_READ;
	logic [BLOCK_ADDR_W-1:0] block_address = '0;
	logic                    device_ok = 1'b0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic                    status;
	logic                    hit;
	logic [LINE_IDX_W-1:0]   line_index;
	logic                    fill_line;
	logic                    store_line;
	logic                    pass_through;

	// Predicted directory: tags, valid bits, round-robin pointer and the enable register
	tag_t  dir_tag [LINES];
	bit    dir_valid [LINES];
	line_t rr_ptr;
	bit    caching_on;

	outcome_t pending_outcomes[$];
	int       mismatch_count = 0;
	int       idle_cycles = 0;
	int       out_hold_left = 0;

	// When set, neither side inserts gaps or stalls
	bit steady_flow = 1'b0;

	// Addresses that random accesses mostly draw from, so that hits and evictions occur
	logic [BLOCK_ADDR_W-1:0] addr_pool [16];
	int                      pool_size = 1;

	block_cache_tag_directory u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.block_address(block_address),
		.device_ok    (device_ok),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.hit          (hit),
		.line_index   (line_index),
		.fill_line    (fill_line),
		.store_line   (store_line),
		.pass_through (pass_through)
	);

	always #10 clk = ~clk;

	// Gap length for either side: mostly none, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady_flow || r < 60) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(4, 30);
	endfunction

	// Clear every line and rewind the pointer, as the invalidate access does
	function automatic void clear_directory();
		for (int i = 0; i < LINES; i++) begin
			dir_tag[i] = '0;
			dir_valid[i] = 1'b0;
		end
		rr_ptr = '0;
	endfunction

	// Take the line under the pointer and step the pointer round-robin
	function automatic line_t claim_line();
		line_t victim;
		victim = rr_ptr;
		rr_ptr = line_t'((int'(rr_ptr) + 1) % LINES);
		return victim;
	endfunction

	// Work out the result of one access and update the predicted directory
	function automatic outcome_t predict_access(input mode_t m,
			input logic [BLOCK_ADDR_W-1:0] addr, input bit ok);
		outcome_t r;
		tag_t     t;
		int       found;
		line_t    victim;
		r = '0;
		t = tag_t'(addr);
		found = -1;
		for (int i = LINES - 1; i >= 0; i--) begin
			// scan downward so the lowest matching line is the one kept
			if (dir_valid[i] && dir_tag[i] == t) begin
				found = i;
			end
		end
		case (m)
			MODE_INVAL: begin
				// works whether or not caching is on
				clear_directory();
			end
			MODE_RSVD: begin
				// reserved mode: no state change, all-zero result
			end
			default: begin
				if (!caching_on) begin
					r.status = !ok;
					r.pass_through = 1'b1;
				end else if (m == MODE_READ) begin
					if (found >= 0) begin
						// read hit ignores the device outcome
						r.hit = 1'b1;
						r.line_index = LINE_IDX_W'(found);
					end else begin
						// the pointer advances even when the fill fails
						victim = claim_line();
						r.line_index = LINE_IDX_W'(victim);
						if (ok) begin
							dir_tag[victim] = t;
							dir_valid[victim] = 1'b1;
							r.fill_line = 1'b1;
						end else begin
							r.status = 1'b1;
						end
					end
				end else begin
					if (!ok) begin
						// failed write leaves everything, pointer included
						r.status = 1'b1;
					end else begin
						if (found >= 0) begin
							r.hit = 1'b1;
							r.line_index = LINE_IDX_W'(found);
						end else begin
							victim = claim_line();
							dir_tag[victim] = t;
							dir_valid[victim] = 1'b1;
							r.line_index = LINE_IDX_W'(victim);
						end
						r.store_line = 1'b1;
					end
				end
			end
		endcase
		return r;
	endfunction

	// Check each result item against the oldest prediction, then predict each accepted
	// access item; also track register writes and drive the result stall.
	always @(posedge clk) begin : result_check
		outcome_t want;
		outcome_t got;
		bit       moved;
		int       gap;
		moved = 1'b0;
		got = '{status, hit, line_index, fill_line, store_line, pass_through};

		if (out_valid && !out_stall) begin
			moved = 1'b1;
			if (pending_outcomes.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS) begin
					$display("unexpected result: status=%0d hit=%0d line=%0d fill=%0d store=%0d pass=%0d",
						got.status, got.hit, got.line_index, got.fill_line, got.store_line,
						got.pass_through);
				end
			end else begin
				want = pending_outcomes.pop_front();
				if (got.status !== want.status || got.hit !== want.hit ||
						got.line_index !== want.line_index ||
						got.fill_line !== want.fill_line ||
						got.store_line !== want.store_line ||
						got.pass_through !== want.pass_through) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS) begin
						$display("mismatch: expected status=%0d hit=%0d line=%0d fill=%0d store=%0d pass=%0d",
							want.status, want.hit, want.line_index, want.fill_line,
							want.store_line, want.pass_through);
						$display("          actual   status=%0d hit=%0d line=%0d fill=%0d store=%0d pass=%0d",
							got.status, got.hit, got.line_index, got.fill_line,
							got.store_line, got.pass_through);
					end
				end
			end
		end

		if (cfg_we) begin
			caching_on = cfg_wdata;
		end

		if (in_valid && !in_stall) begin
			moved = 1'b1;
			pending_outcomes.push_back(predict_access(mode_t'(mode), block_address,
				device_ok));
		end

		idle_cycles = moved ? 0 : idle_cycles + 1;

		// Hold the result channel for a random stretch now and then
		if (out_hold_left > 0) begin
			out_hold_left--;
			out_stall <= 1'b1;
		end else begin
			gap = pick_gap();
			out_hold_left = (gap > 0) ? gap - 1 : 0;
			out_stall <= (gap > 0);
		end
	end

	initial begin : watchdog
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
		end
		$display("FAIL block_cache_tag_directory");
		$finish;
	end

	// Offer one access item after an optional gap and hold it until accepted.
	// Keep valid high when no gap follows, so back-to-back items stream.
	task automatic send_access(input mode_t m, input logic [BLOCK_ADDR_W-1:0] addr,
			input bit ok);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		block_address <= addr;
		device_ok <= ok;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
	endtask

	// Drop valid and wait until every predicted result has arrived, then let the
	// pipeline settle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_outcomes.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	// Write the enable register, only once the block is idle
	task automatic write_enable(input bit value);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Refill the address pool; now and then put the all-zero and all-one addresses in it
	task automatic refresh_pool();
		pool_size = $urandom_range(4, 16);
		for (int i = 0; i < pool_size; i++) begin
			addr_pool[i] = $urandom();
		end
		if ($urandom_range(0, 1)) begin
			addr_pool[0] = '0;
		end
		if ($urandom_range(0, 1)) begin
			addr_pool[pool_size - 1] = '1;
		end
	endtask

	// One random access: mostly pool addresses with sane modes, some pure noise
	task automatic send_random_access();
		logic [BLOCK_ADDR_W-1:0] addr;
		mode_t                   m;
		bit                      ok;
		int                      r;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			m = mode_t'($urandom_range(0, 3));
			addr = $urandom();
			ok = $urandom_range(0, 1);
		end else begin
			r = $urandom_range(0, 99);
			if (r < 50) begin
				m = MODE_READ;
			end else if (r < 95) begin
				m = MODE_WRITE;
			end else if (r < 98) begin
				m = MODE_INVAL;
			end else begin
				m = MODE_RSVD;
			end
			addr = ($urandom_range(0, 99) < 88) ? addr_pool[$urandom_range(0, pool_size - 1)]
				: $urandom();
			ok = ($urandom_range(0, 99) < 85);
		end
		send_access(m, addr, ok);
	endtask

	// Edge cases with caching on: hits, misses, device failures, invalidate, wrap
	task automatic test_directed();
		send_access(MODE_READ, 32'h0000_0000, 1'b1);
		send_access(MODE_READ, 32'h0000_0000, 1'b1);
		// failed fill: pointer moves, line stays invalid
		send_access(MODE_READ, 32'hFFFF_FFFF, 1'b0);
		send_access(MODE_READ, 32'hFFFF_FFFF, 1'b1);
		send_access(MODE_WRITE, 32'hFFFF_FFFF, 1'b1);
		send_access(MODE_WRITE, 32'h1234_5678, 1'b1);
		// failed write: nothing changes
		send_access(MODE_WRITE, 32'hAAAA_AAAA, 1'b0);
		send_access(MODE_READ, 32'hAAAA_AAAA, 1'b1);
		// read hit ignores a failing device
		send_access(MODE_READ, 32'h0000_0000, 1'b0);
		send_access(MODE_RSVD, 32'h5555_5555, 1'b1);
		send_access(MODE_INVAL, 32'hFFFF_FFFF, 1'b0);
		send_access(MODE_READ, 32'h0000_0000, 1'b1);
		// fill every line and wrap the pointer, evicting address zero
		for (int i = 0; i < LINES; i++) begin
			send_access(MODE_WRITE, 32'h8000_0000 + i, 1'b1);
		end
		send_access(MODE_READ, 32'h0000_0000, 1'b1);
		send_access(MODE_WRITE, 32'h0000_0000, 1'b0);
		send_access(MODE_READ, 32'h8000_0003, 1'b0);
	endtask

	// Pass-through with caching off, invalidate while off, then caching back on
	task automatic test_disabled();
		write_enable(1'b0);
		send_access(MODE_READ, 32'h8000_0001, 1'b1);
		send_access(MODE_READ, 32'h8000_0001, 1'b0);
		send_access(MODE_WRITE, 32'hFFFF_FFFF, 1'b1);
		send_access(MODE_WRITE, 32'h0000_0000, 1'b0);
		send_access(MODE_RSVD, 32'hFFFF_FFFF, 1'b1);
		write_enable(1'b1);
		// directory contents survive a disabled stretch
		send_access(MODE_READ, 32'h8000_0001, 1'b1);
		write_enable(1'b0);
		send_access(MODE_INVAL, 32'h0000_0000, 1'b1);
		write_enable(1'b1);
		send_access(MODE_READ, 32'h8000_0001, 1'b1);
	endtask

	// Long random run with caching on; change flow style and pool between stretches
	task automatic test_random_cached();
		refresh_pool();
		for (int n = 0; n < 1200; n++) begin
			if (n % 150 == 0) begin
				steady_flow = ($urandom_range(0, 3) == 0);
				if ($urandom_range(0, 1)) begin
					refresh_pool();
				end
			end
			// pause the sender once until every result is back
			if (n == 600) begin
				wait_idle();
			end
			send_random_access();
		end
		steady_flow = 1'b0;
	endtask

	// Alternate the enable register across random stretches, ending enabled
	task automatic test_enable_toggle();
		for (int p = 0; p < 4; p++) begin
			write_enable(p[0]);
			refresh_pool();
			for (int n = 0; n < 100; n++) begin
				send_random_access();
			end
		end
		write_enable(1'b1);
	endtask

	initial begin
		clear_directory();
		caching_on = 1'b1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_disabled();
		test_random_cached();
		test_enable_toggle();

		// Drain the last results and give the pipeline time to show any extra item
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_outcomes.size() != 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);

		if (pending_outcomes.size() != 0) begin
			$display("results never arrived: %0d", pending_outcomes.size());
		end
		if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
			$display("PASS block_cache_tag_directory");
		end else begin
			$display("FAIL block_cache_tag_directory");
		end
		$finish;
	end

endmodule
